// ===== sv/cpe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, character codes and arithmetic helpers of the complex postfix evaluator.
package cpe_pkg;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       end_of_expression;
  } cpe_in_t;

  typedef struct packed {
    logic signed [31:0] result_real;
    logic signed [31:0] result_imag;
    logic [1:0]         status;
  } cpe_out_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_SAT   = 2'd3
  } cpe_status_e;

  // One stack entry: a complex value with 32-bit signed parts.
  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } cpe_entry_t;

  // Shift control of one stack slot.
  typedef struct packed {
    logic shift_down;
    logic shift_up;
  } cpe_cell_ctrl_t;

  // Decoded stack command that travels down the pipeline with each item.
  typedef struct packed {
    logic        last;
    logic        push;
    logic        op;
    logic        mul;
    logic        empty;
    cpe_status_e flag;
  } cpe_cmd_t;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [31:0] LIM_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] LIM_NEG = 32'h8000_0000;

  localparam logic signed [64:0] SAT_HI = 65'sd2147483647;
  localparam logic signed [64:0] SAT_LO = -65'sd2147483648;

  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_AW    = 2;
  localparam int OFIFO_CW    = 3;

  // Appends one decimal digit; bit 32 of the result reports saturation at the limit.
  function automatic logic [32:0] acc_digit(logic [31:0] acc, logic [3:0] dig,
                                            logic [31:0] limit);
    logic [35:0] v;
    v = (36'(acc) << 3) + (36'(acc) << 1) + 36'(dig);
    if (v > 36'(limit)) begin
      return {1'b1, limit};
    end
    return {1'b0, v[31:0]};
  endfunction

  // Clamps to the signed 32-bit range; bit 32 of the result reports saturation.
  function automatic logic [32:0] clamp32(logic signed [64:0] v);
    if (v > SAT_HI) begin
      return {1'b1, 32'h7FFF_FFFF};
    end
    if (v < SAT_LO) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[31:0]};
  endfunction

endpackage

// ===== sv/complex_postfix_evaluator_core.sv =====
`timescale 1ns / 1ps
// Top level of the complex postfix evaluator: parser, shifting stack, arithmetic and result queue.
//
//   Channel  Signals                              Transfer when
//   input    in_valid_i, in_ready_o, in_data_i    in_valid_i && in_ready_o
//   output   out_valid_o, out_ready_i, out_data_o out_valid_o && out_ready_i
//
// One character is taken per cycle while in_ready_o is high. Each one passes a
// decode stage, an operand and product stage and a writeback stage; the result is
// offered once writeback has put it into the result queue. The stack is a row of slots
// that shift by one position per cycle. Reset clears control state only; the stack
// slots need no clearing. in_ready_o drops only while the four-entry result queue,
// together with results still in the pipeline, is full.
module complex_postfix_evaluator_core #(
  parameter int STACK_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cpe_pkg::cpe_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cpe_pkg::cpe_out_t out_data_o
);
  import cpe_pkg::*;

  localparam int CntW = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(STACK_DEPTH);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_REAL = 2'd1;
  localparam logic [1:0] PH_IMAG = 2'd2;

  // Parser state
  logic [1:0]      phase_q;
  logic [7:0]      prev_q;
  logic [31:0]     lit_re_q, lit_im_q;
  logic            lit_neg_q;
  logic [CntW-1:0] count_q;

  // Decode signals
  logic            in_fire, last;
  logic [7:0]      ch;
  logic            is_digit;
  logic [3:0]      dig;
  logic [32:0]     acc_res;
  logic [1:0]      ph_mid;
  logic [31:0]     re_n, im_n, push_im;
  logic            neg_n, acc_sat, op_req, op_mul, lit_done, push_req;
  logic            op_ok, push_ok, empty;
  logic [CntW-1:0] cnt1, cnt2;
  cpe_status_e     flag;
  cpe_cmd_t        cmd;

  // Pipeline registers
  logic            p1_valid_q, p2_valid_q;
  cpe_cmd_t        p1_cmd_q, p2_cmd_q;
  cpe_entry_t      p1_val_q, p2_val_q;

  // Stack, arithmetic and writeback
  cpe_entry_t      slot_data [STACK_DEPTH];
  cpe_entry_t      op_a, op_b, alu_res, wb_val;
  logic            alu_sat, fwd;
  cpe_cell_ctrl_t  ctrl_top, ctrl_rest;
  cpe_status_e     item_flag, status_now, sticky_q;
  logic            wb_live, fifo_wr;
  cpe_out_t        fifo_data;
  logic [OFIFO_CW-1:0] fifo_count;
  logic [OFIFO_CW-1:0] inflight;

  assign in_fire = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------- decode
  always_comb begin
    ch       = in_data_i.ascii_char;
    last     = in_data_i.end_of_expression;
    is_digit = ch inside {[CH_ZERO:CH_NINE]};
    dig      = 4'(ch - CH_ZERO);
    if (phase_q == PH_REAL) begin
      acc_res = acc_digit(lit_re_q, dig, LIM_POS);
    end else begin
      acc_res = acc_digit(lit_im_q, dig, lit_neg_q ? LIM_NEG : LIM_POS);
    end

    ph_mid   = phase_q;
    re_n     = lit_re_q;
    im_n     = lit_im_q;
    neg_n    = lit_neg_q;
    acc_sat  = 1'b0;
    op_req   = 1'b0;
    op_mul   = 1'b0;
    lit_done = 1'b0;

    case (phase_q)
      PH_REAL: begin
        if (is_digit) begin
          re_n    = acc_res[31:0];
          acc_sat = acc_res[32];
        end else begin
          neg_n  = (ch == CH_MINUS);
          ph_mid = PH_IMAG;
        end
      end
      PH_IMAG: begin
        if (is_digit) begin
          im_n    = acc_res[31:0];
          acc_sat = acc_res[32];
        end else begin
          lit_done = 1'b1;
        end
      end
      default: begin
        if (is_digit) begin
          re_n   = 32'(dig);
          im_n   = '0;
          neg_n  = 1'b0;
          ph_mid = PH_REAL;
        end else if (prev_q == CH_SPACE && ch == CH_PLUS) begin
          op_req = 1'b1;
        end else if (prev_q == CH_SPACE && ch == CH_STAR) begin
          op_req = 1'b1;
          op_mul = 1'b1;
        end
      end
    endcase

    // A literal still open at the end of the expression is pushed as it stands.
    push_req = lit_done || (last && ph_mid != PH_IDLE);
    push_im  = neg_n ? 32'(-im_n) : im_n;

    op_ok   = op_req && (count_q >= CntW'(2));
    cnt1    = op_ok ? count_q - CntW'(1) : count_q;
    push_ok = push_req && (cnt1 < CntFull);
    cnt2    = push_ok ? cnt1 + CntW'(1) : cnt1;
    empty   = (cnt2 == '0);

    if (acc_sat) begin
      flag = ST_SAT;
    end else if (op_req && !op_ok) begin
      flag = ST_UNDER;
    end else if (push_req && !push_ok) begin
      flag = ST_OVER;
    end else if (last && empty) begin
      flag = ST_UNDER;
    end else begin
      flag = ST_OK;
    end

    cmd.last  = last;
    cmd.push  = push_ok;
    cmd.op    = op_ok;
    cmd.mul   = op_mul;
    cmd.empty = empty;
    cmd.flag  = flag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      prev_q    <= '0;
      lit_re_q  <= '0;
      lit_im_q  <= '0;
      lit_neg_q <= 1'b0;
      count_q   <= '0;
    end else if (in_fire) begin
      count_q <= last ? '0 : cnt2;
      prev_q  <= last ? '0 : ch;
      if (last || push_req) begin
        phase_q   <= PH_IDLE;
        lit_re_q  <= '0;
        lit_im_q  <= '0;
        lit_neg_q <= 1'b0;
      end else begin
        phase_q   <= ph_mid;
        lit_re_q  <= re_n;
        lit_im_q  <= im_n;
        lit_neg_q <= neg_n;
      end
    end
  end

  // ---------------------------------------------------------------- pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      p1_cmd_q   <= '0;
      p2_cmd_q   <= '0;
    end else begin
      p1_valid_q <= in_fire;
      p2_valid_q <= p1_valid_q;
      if (in_fire) begin
        p1_cmd_q <= cmd;
      end
      p2_cmd_q <= p1_cmd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      p1_val_q.re <= re_n;
      p1_val_q.im <= push_im;
    end
    p2_val_q <= p1_val_q;
  end

  // A literal pushed by the preceding character is still in writeback while an
  // operator reads its operands, so it is taken from there.
  always_comb begin
    fwd = p2_valid_q && p2_cmd_q.push && !p2_cmd_q.last;
    if (fwd) begin
      op_a = p2_val_q;
      op_b = slot_data[0];
    end else begin
      op_a = slot_data[0];
      op_b = slot_data[1];
    end
  end

  cpe_cplx_alu u_alu (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .mul_i  (p1_cmd_q.mul),
    .res_o  (alu_res),
    .sat_o  (alu_sat)
  );

  // ---------------------------------------------------------------- writeback
  always_comb begin
    wb_val  = p2_cmd_q.op ? alu_res : p2_val_q;
    wb_live = p2_valid_q && !p2_cmd_q.last;

    if (p2_cmd_q.flag != ST_OK) begin
      item_flag = p2_cmd_q.flag;
    end else if (p2_cmd_q.op && alu_sat) begin
      item_flag = ST_SAT;
    end else begin
      item_flag = ST_OK;
    end
    status_now = (sticky_q != ST_OK) ? sticky_q : item_flag;

    ctrl_top.shift_down  = wb_live && (p2_cmd_q.push || p2_cmd_q.op);
    ctrl_top.shift_up    = 1'b0;
    ctrl_rest.shift_down = wb_live && p2_cmd_q.push;
    ctrl_rest.shift_up   = wb_live && p2_cmd_q.op;

    fifo_wr = p2_valid_q && p2_cmd_q.last;
    if (p2_cmd_q.empty) begin
      fifo_data.result_real = '0;
      fifo_data.result_imag = '0;
    end else if (p2_cmd_q.push || p2_cmd_q.op) begin
      fifo_data.result_real = wb_val.re;
      fifo_data.result_imag = wb_val.im;
    end else begin
      fifo_data.result_real = slot_data[0].re;
      fifo_data.result_imag = slot_data[0].im;
    end
    fifo_data.status = status_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sticky_q <= ST_OK;
    end else if (p2_valid_q) begin
      sticky_q <= p2_cmd_q.last ? ST_OK : status_now;
    end
  end

  // ---------------------------------------------------------------- stack slots
  for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_slot
    if (gi == 0) begin : g_head
      cpe_stack_cell u_slot (
        .clk_i   (clk_i),
        .ctrl_i  (ctrl_top),
        .above_i (wb_val),
        .below_i (slot_data[1]),
        .data_o  (slot_data[0])
      );
    end else if (gi == STACK_DEPTH - 1) begin : g_tail
      cpe_stack_cell u_slot (
        .clk_i   (clk_i),
        .ctrl_i  (ctrl_rest),
        .above_i (slot_data[gi-1]),
        .below_i ('0),
        .data_o  (slot_data[gi])
      );
    end else begin : g_mid
      cpe_stack_cell u_slot (
        .clk_i   (clk_i),
        .ctrl_i  (ctrl_rest),
        .above_i (slot_data[gi-1]),
        .below_i (slot_data[gi+1]),
        .data_o  (slot_data[gi])
      );
    end
  end

  // ---------------------------------------------------------------- results
  cpe_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fifo_wr),
    .wr_data_i  (fifo_data),
    .rd_valid_o (out_valid_o),
    .rd_ready_i (out_ready_i),
    .rd_data_o  (out_data_o),
    .count_o    (fifo_count)
  );

  // Room is reserved for every result already on its way to the queue.
  assign inflight = OFIFO_CW'(p1_valid_q && p1_cmd_q.last)
                  + OFIFO_CW'(p2_valid_q && p2_cmd_q.last);
  assign in_ready_o = (fifo_count + inflight) < OFIFO_CW'(OFIFO_DEPTH);

endmodule

// ===== sv/cpe_stack_cell.sv =====
`timescale 1ns / 1ps
// One slot of the shifting operand stack.
module cpe_stack_cell (
  input  logic                   clk_i,
  input  cpe_pkg::cpe_cell_ctrl_t ctrl_i,
  input  cpe_pkg::cpe_entry_t    above_i,
  input  cpe_pkg::cpe_entry_t    below_i,
  output cpe_pkg::cpe_entry_t    data_o
);
  import cpe_pkg::*;

  cpe_entry_t data_d, data_q;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_down) begin
      data_d = above_i;
    end else if (ctrl_i.shift_up) begin
      data_d = below_i;
    end
  end

  // Stack contents are only read below the fill count, so they need no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== sv/cpe_cplx_alu.sv =====
`timescale 1ns / 1ps
// Complex add and multiply unit: registered partial products, then combine and saturate.
module cpe_cplx_alu (
  input  logic                clk_i,
  input  cpe_pkg::cpe_entry_t op_a_i,
  input  cpe_pkg::cpe_entry_t op_b_i,
  input  logic                mul_i,
  output cpe_pkg::cpe_entry_t res_o,
  output logic                sat_o
);
  import cpe_pkg::*;

  logic signed [31:0] ar, ai, br, bi;
  logic signed [63:0] pp_d [4];
  logic signed [63:0] pp_q [4];
  logic signed [64:0] rr, ri;
  logic [32:0]        cr, ci;

  assign ar = op_a_i.re;
  assign ai = op_a_i.im;
  assign br = op_b_i.re;
  assign bi = op_b_i.im;

  // The real part is always term 0 minus term 1, the imaginary part term 2 plus term 3,
  // so an add loads the negated real operand into term 1.
  always_comb begin
    if (mul_i) begin
      pp_d[0] = ar * br;
      pp_d[1] = ai * bi;
      pp_d[2] = ar * bi;
      pp_d[3] = ai * br;
    end else begin
      pp_d[0] = 64'(ar);
      pp_d[1] = -64'(br);
      pp_d[2] = 64'(ai);
      pp_d[3] = 64'(bi);
    end
  end

  always_ff @(posedge clk_i) begin
    pp_q <= pp_d;
  end

  always_comb begin
    rr = 65'(pp_q[0]) - 65'(pp_q[1]);
    ri = 65'(pp_q[2]) + 65'(pp_q[3]);
    cr = clamp32(rr);
    ci = clamp32(ri);
    res_o.re = cr[31:0];
    res_o.im = ci[31:0];
    sat_o = cr[32] | ci[32];
  end

endmodule

// ===== sv/cpe_out_fifo.sv =====
`timescale 1ns / 1ps
// Small result queue between the evaluation pipeline and the output channel.
module cpe_out_fifo (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 wr_valid_i,
  input  cpe_pkg::cpe_out_t                    wr_data_i,
  output logic                                 rd_valid_o,
  input  logic                                 rd_ready_i,
  output cpe_pkg::cpe_out_t                    rd_data_o,
  output logic [cpe_pkg::OFIFO_CW-1:0]         count_o
);
  import cpe_pkg::*;

  cpe_out_t              mem_q [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0]   wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [OFIFO_CW-1:0]   count_d, count_q;
  logic                  rd_fire;

  assign rd_valid_o = (count_q != '0);
  assign rd_fire    = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign count_o    = count_q;

  always_comb begin
    wr_ptr_d = wr_valid_i ? wr_ptr_q + OFIFO_AW'(1) : wr_ptr_q;
    rd_ptr_d = rd_fire ? rd_ptr_q + OFIFO_AW'(1) : rd_ptr_q;
    case ({wr_valid_i, rd_fire})
      2'b10:   count_d = count_q + OFIFO_CW'(1);
      2'b01:   count_d = count_q - OFIFO_CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_valid_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule
